FILE: rtl/cfd_pkg.sv
`default_nettype none

package cfd_pkg;

  // Pending id queue sizing
  localparam int PENDING_LIMIT = 8;
  localparam int PENDING_DEPTH = PENDING_LIMIT + 1;
  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

  // Frame layout
  localparam logic [15:0] MIN_FRAME_LEN = 16'd6;
  localparam logic [15:0] MAX_FRAME_LEN = 16'd261;
  localparam int PAYLOAD_START = 5;
  localparam logic [8:0] ID_POS = 9'(PAYLOAD_START - 2);
  localparam logic [8:0] CMD_POS = 9'(PAYLOAD_START - 1);

  // Register map, selected by paddr[2]
  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_FOOTER = 1'b1;

  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    KIND_PAYLOAD    = 3'd0,
    KIND_QUEUED     = 3'd1,
    KIND_DROPPED    = 3'd2,
    KIND_BAD_HEADER = 3'd3,
    KIND_BAD_LENGTH = 3'd4,
    KIND_BAD_FOOTER = 3'd5,
    KIND_DUPLICATE  = 3'd6,
    KIND_RELEASED   = 3'd7
  } kind_t;

  typedef struct packed {
    logic [7:0] header;
    logic [7:0] footer;
  } cfg_t;

  typedef struct packed {
    logic             hit;
    logic             room;
    logic             empty;
    logic [7:0]       oldest;
    logic [CNT_W-1:0] count;
  } pend_status_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] id;
  } pend_cmd_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] msg_id;
    logic [7:0] command_code;
    logic [7:0] data_byte;
    logic [7:0] payload_length;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/cfd_cfg.sv
`default_nettype none

module cfd_cfg
  import cfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic [7:0] header;
  logic [7:0] footer;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Write registers on the access phase of a write transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      header <= '0;
      footer <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_HEADER: header <= pwdata[7:0];
        REG_FOOTER: footer <= pwdata[7:0];
        default:    header <= header;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (paddr[2])
      REG_HEADER: prdata = {24'd0, header};
      REG_FOOTER: prdata = {24'd0, footer};
      default:    prdata = '0;
    endcase
  end

  assign cfg.header = header;
  assign cfg.footer = footer;

endmodule

`default_nettype wire

FILE: rtl/cfd_pending.sv
`default_nettype none

module cfd_pending
  import cfd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire pend_cmd_t    cmd,
  output pend_status_t stat
);

  logic [7:0]       ids [PENDING_DEPTH];
  logic [CNT_W-1:0] count;
  logic             room;
  logic             empty;
  logic             hit;

  assign room  = count < CNT_W'(PENDING_DEPTH);
  assign empty = count == '0;

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.pop && !empty) begin
      count <= count - 1'b1;
    end else if (cmd.push && room) begin
      count <= count + 1'b1;
    end
  end

  // Shift down on release, append at the fill count on push
  always_ff @(posedge clk) begin
    if (cmd.pop && !empty) begin
      for (int i = 0; i < PENDING_DEPTH - 1; i++) begin
        ids[i] <= ids[i+1];
      end
    end else if (cmd.push && room) begin
      for (int i = 0; i < PENDING_DEPTH; i++) begin
        if (count == CNT_W'(i)) begin
          ids[i] <= cmd.id;
        end
      end
    end
  end

  // Parallel compare against all live entries
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < PENDING_DEPTH; i++) begin
      if ((CNT_W'(i) < count) && (ids[i] == cmd.id)) begin
        hit = 1'b1;
      end
    end
  end

  assign stat.hit    = hit;
  assign stat.room   = room;
  assign stat.empty  = empty;
  assign stat.oldest = ids[0];
  assign stat.count  = count;

endmodule

`default_nettype wire

FILE: rtl/cfd_parser.sv
`default_nettype none

module cfd_parser
  import cfd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire logic         operation,
  input  wire logic [7:0]   rx_byte,
  input  wire cfg_t         cfg,
  input  wire pend_status_t stat,
  output pend_cmd_t         cmd,
  output result_t           res
);

  logic       in_frame, in_frame_next;
  logic       header_ok, header_ok_next;
  logic [8:0] byte_count, byte_count_next;
  logic [7:0] length_high, length_high_next;
  logic [8:0] frame_length, frame_length_next;
  logic [7:0] frame_id, frame_id_next;
  logic [7:0] frame_command, frame_command_next;

  logic [15:0] len;
  logic        len_ok;
  logic        last_byte;
  logic [7:0]  plen;

  assign len       = {length_high, rx_byte};
  assign len_ok    = (len >= MIN_FRAME_LEN) && (len <= MAX_FRAME_LEN);
  assign last_byte = ({1'b0, byte_count} + 10'd1) >= {1'b0, frame_length};
  assign plen      = frame_length[7:0] - MIN_FRAME_LEN[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      header_ok     <= 1'b0;
      byte_count    <= '0;
      length_high   <= '0;
      frame_length  <= '0;
      frame_id      <= '0;
      frame_command <= '0;
    end else begin
      in_frame      <= in_frame_next;
      header_ok     <= header_ok_next;
      byte_count    <= byte_count_next;
      length_high   <= length_high_next;
      frame_length  <= frame_length_next;
      frame_id      <= frame_id_next;
      frame_command <= frame_command_next;
    end
  end

  // Decode one transaction: advance frame state, pick the result
  always_comb begin
    in_frame_next      = in_frame;
    header_ok_next     = header_ok;
    byte_count_next    = byte_count;
    length_high_next   = length_high;
    frame_length_next  = frame_length;
    frame_id_next      = frame_id;
    frame_command_next = frame_command;

    cmd.push = 1'b0;
    cmd.pop  = 1'b0;
    cmd.id   = frame_id;

    res.valid          = 1'b0;
    res.kind           = KIND_PAYLOAD;
    res.msg_id         = '0;
    res.command_code   = '0;
    res.data_byte      = '0;
    res.payload_length = '0;

    if (accept) begin
      case (op_t'(operation))
        OP_RELEASE: begin
          if (!stat.empty) begin
            cmd.pop    = 1'b1;
            res.valid  = 1'b1;
            res.kind   = KIND_RELEASED;
            res.msg_id = stat.oldest;
          end
        end
        OP_BYTE: begin
          if (!in_frame) begin
            if (byte_count == 9'd0) begin
              header_ok_next  = rx_byte == cfg.header;
              byte_count_next = 9'd1;
            end else if (byte_count == 9'd1) begin
              length_high_next = rx_byte;
              byte_count_next  = 9'd2;
            end else if (!header_ok) begin
              // Header is judged only once the length has arrived
              header_ok_next  = 1'b0;
              byte_count_next = '0;
              res.valid       = 1'b1;
              res.kind        = KIND_BAD_HEADER;
            end else if (!len_ok) begin
              header_ok_next  = 1'b0;
              byte_count_next = '0;
              res.valid       = 1'b1;
              res.kind        = KIND_BAD_LENGTH;
            end else begin
              frame_length_next = len[8:0];
              in_frame_next     = 1'b1;
              byte_count_next   = 9'd3;
            end
          end else if (last_byte) begin
            // Footer position: close the frame and classify it
            in_frame_next      = 1'b0;
            header_ok_next     = 1'b0;
            byte_count_next    = '0;
            res.valid          = 1'b1;
            res.payload_length = plen;
            if (rx_byte != cfg.footer) begin
              res.kind = KIND_BAD_FOOTER;
            end else begin
              res.msg_id       = frame_id;
              res.command_code = frame_command;
              if (stat.hit) begin
                res.kind = KIND_DUPLICATE;
              end else if (stat.room) begin
                cmd.push = 1'b1;
                res.kind = KIND_QUEUED;
              end else begin
                res.kind = KIND_DROPPED;
              end
            end
          end else if (byte_count == ID_POS) begin
            frame_id_next   = rx_byte;
            byte_count_next = byte_count + 9'd1;
          end else if (byte_count == CMD_POS) begin
            frame_command_next = rx_byte;
            byte_count_next    = byte_count + 9'd1;
          end else begin
            // Pass payload on before the footer is known
            byte_count_next = byte_count + 9'd1;
            res.valid       = 1'b1;
            res.kind        = KIND_PAYLOAD;
            res.data_byte   = rx_byte;
          end
        end
        default: begin
          res.valid = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/command_frame_deframer_top.sv
// Command frame deframer.
// A result is registered and presented in the cycle after its transaction.
// Throughput: one transaction per cycle while in_ready holds; id compare over
// nine queue entries and frame decode settle between input and result register.
// Reset (synchronous, active high) clears frame tracking, the pending count,
// the output valid and both configuration registers.
`default_nettype none

module command_frame_deframer_top
  import cfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       kind,
  output logic [7:0]       msg_id,
  output logic [7:0]       command_code,
  output logic [7:0]       data_byte,
  output logic [7:0]       payload_length
);

  cfg_t         cfg;
  pend_status_t stat;
  pend_cmd_t    cmd;
  result_t      res;
  logic         accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  cfd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cfd_pending u_pending (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  cfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (operation),
    .rx_byte   (rx_byte),
    .cfg       (cfg),
    .stat      (stat),
    .cmd       (cmd),
    .res       (res)
  );

  // Result register: reload whenever the downstream side is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && res.valid) begin
      kind           <= res.kind;
      msg_id         <= res.msg_id;
      command_code   <= res.command_code;
      data_byte      <= res.data_byte;
      payload_length <= res.payload_length;
    end
  end

  // Queue never holds more ids than it has entries
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= CNT_W'(PENDING_DEPTH))
    else $error("pending count beyond queue depth");

  // A queued frame grows the pending queue by one
  a_queue_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && res.valid && res.kind == KIND_QUEUED)
      |=> stat.count == $past(stat.count) + 1'b1)
    else $error("queued frame did not add a pending id");

  // A release with ids pending yields a released result next cycle
  a_release_result: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_RELEASE && !stat.empty)
      |=> out_valid && kind == KIND_RELEASED)
    else $error("release of pending id gave no released result");

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import cfd_pkg::*;

  localparam logic [2:0] ADDR_HEADER = {REG_HEADER, 2'b00};
  localparam logic [2:0] ADDR_FOOTER = {REG_FOOTER, 2'b00};

  typedef struct packed {
    op_t        op;
    logic [7:0] b;
  } rx_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] msg_id;
    logic [7:0] command_code;
    logic [7:0] data_byte;
    logic [7:0] payload_length;
  } frame_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = 1'b0;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [2:0]  kind;
  logic [7:0]  msg_id;
  logic [7:0]  command_code;
  logic [7:0]  data_byte;
  logic [7:0]  payload_length;

  command_frame_deframer_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .msg_id         (msg_id),
    .command_code   (command_code),
    .data_byte      (data_byte),
    .payload_length (payload_length)
  );

  // Deframer shadow state
  logic [7:0] cfg_header = '0;
  logic [7:0] cfg_footer = '0;
  logic       rx_in_frame = 1'b0;
  logic       rx_header_ok = 1'b0;
  logic [8:0] rx_pos = '0;
  logic [7:0] rx_len_hi = '0;
  logic [8:0] rx_frame_len = '0;
  logic [7:0] rx_frame_id = '0;
  logic [7:0] rx_frame_cmd = '0;
  logic [7:0] pend_ids [PENDING_DEPTH];
  int         pend_count = 0;

  rx_item_t      rx_items [$];
  frame_report_t frame_reports_due [$];

  logic in_fire = 1'b0;
  int   items_queued = 0;
  int   items_taken = 0;
  int   releases_taken = 0;
  int   reports_seen = 0;
  int   mismatches = 0;
  int   kind_seen [8];
  int   gap_left = 0;
  int   burst_left = 1;
  int   ready_hold = 0;
  logic [15:0] ready_mask = 16'hFFFF;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Drop back to waiting for a header
  function automatic void abandon_frame();
    rx_in_frame = 1'b0;
    rx_header_ok = 1'b0;
    rx_pos = '0;
  endfunction

  // Advance the shadow deframer by one transaction and queue what it reports
  function automatic void decode_rx_item(op_t op, logic [7:0] b);
    logic [15:0]   len;
    logic [8:0]    plen9;
    frame_report_t r;
    logic          hit;
    logic          emit;
    int            i;
    r = '0;
    emit = 1'b0;
    hit = 1'b0;
    if (op == OP_RELEASE) begin
      if (pend_count != 0) begin
        r.kind = KIND_RELEASED;
        r.msg_id = pend_ids[0];
        for (i = 0; i < PENDING_DEPTH - 1; i++) pend_ids[i] = pend_ids[i + 1];
        pend_count--;
        emit = 1'b1;
      end
    end else if (!rx_in_frame) begin
      if (rx_pos == 0) begin
        rx_header_ok = (b == cfg_header);
        rx_pos = 9'd1;
      end else if (rx_pos == 1) begin
        rx_len_hi = b;
        rx_pos = 9'd2;
      end else begin
        // header and length are judged together at the third byte
        len = {rx_len_hi, b};
        if (!rx_header_ok) begin
          abandon_frame();
          r.kind = KIND_BAD_HEADER;
          emit = 1'b1;
        end else if (len < MIN_FRAME_LEN || len > MAX_FRAME_LEN) begin
          abandon_frame();
          r.kind = KIND_BAD_LENGTH;
          emit = 1'b1;
        end else begin
          rx_frame_len = len[8:0];
          rx_in_frame = 1'b1;
          rx_pos = ID_POS;
        end
      end
    end else if (int'(rx_pos) + 1 >= int'(rx_frame_len)) begin
      // last byte: footer, then the pending id table
      plen9 = rx_frame_len - 9'(MIN_FRAME_LEN);
      r.payload_length = plen9[7:0];
      abandon_frame();
      emit = 1'b1;
      if (b != cfg_footer) begin
        r.kind = KIND_BAD_FOOTER;
      end else begin
        for (i = 0; i < pend_count; i++) if (pend_ids[i] == rx_frame_id) hit = 1'b1;
        r.msg_id = rx_frame_id;
        r.command_code = rx_frame_cmd;
        if (hit) begin
          r.kind = KIND_DUPLICATE;
        end else if (pend_count <= PENDING_LIMIT) begin
          pend_ids[pend_count] = rx_frame_id;
          pend_count++;
          r.kind = KIND_QUEUED;
        end else begin
          r.kind = KIND_DROPPED;
        end
      end
    end else if (rx_pos == ID_POS) begin
      rx_frame_id = b;
      rx_pos++;
    end else if (rx_pos == CMD_POS) begin
      rx_frame_cmd = b;
      rx_pos++;
    end else begin
      rx_pos++;
      r.kind = KIND_PAYLOAD;
      r.data_byte = b;
      emit = 1'b1;
    end
    if (emit) frame_reports_due.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%02h, actual 0x%02h", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  // Sample both channels and the register port at the rising edge
  always @(posedge clk) begin : monitor
    frame_report_t want;
    if (rst) begin
      in_fire = 1'b0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_FOOTER) cfg_footer = pwdata[7:0];
          else cfg_header = pwdata[7:0];
        end else begin
          check_field("prdata", (paddr[2] == REG_FOOTER) ? cfg_footer : cfg_header,
                      prdata[7:0]);
        end
      end
      if (out_valid && out_ready) begin
        reports_seen++;
        kind_seen[kind]++;
        if (frame_reports_due.size() == 0) begin
          $error("unexpected transaction: kind %0d msg_id 0x%02h", kind, msg_id);
          mismatches++;
        end else begin
          want = frame_reports_due.pop_front();
          check_field("kind", {5'b0, want.kind}, {5'b0, kind});
          check_field("msg_id", want.msg_id, msg_id);
          check_field("command_code", want.command_code, command_code);
          check_field("data_byte", want.data_byte, data_byte);
          check_field("payload_length", want.payload_length, payload_length);
        end
      end
      in_fire = in_valid && in_ready;
      if (in_fire) begin
        items_taken++;
        if (operation == OP_RELEASE) releases_taken++;
        decode_rx_item(op_t'(operation), rx_byte);
      end
    end
  end

  // Sender: bursts of random length with random gaps
  always @(negedge clk) begin : sender
    rx_item_t nxt;
    if (!rst && (!in_valid || in_fire)) begin
      if (gap_left > 0 || rx_items.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        nxt = rx_items.pop_front();
        in_valid <= 1'b1;
        operation <= nxt.op;
        rx_byte <= nxt.b;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Receiver: rotate a stall mask, reload it now and then
  always @(negedge clk) begin : receiver
    if (ready_hold == 0) begin
      ready_hold = $urandom_range(20, 80);
      if ($urandom_range(0, 2) == 0) begin
        ready_mask = 16'hFFFF;
      end else begin
        ready_mask = 16'($urandom);
        ready_mask[0] = 1'b1;
      end
    end else begin
      ready_hold--;
      ready_mask = {ready_mask[0], ready_mask[15:1]};
    end
    out_ready <= ready_mask[0];
  end

  function automatic void push_byte(logic [7:0] b);
    rx_item_t it;
    it.op = OP_BYTE;
    it.b = b;
    rx_items.push_back(it);
    items_queued++;
  endfunction

  function automatic void push_release();
    rx_item_t it;
    it.op = OP_RELEASE;
    it.b = 8'($urandom_range(0, 255));
    rx_items.push_back(it);
    items_queued++;
  endfunction

  // Whole frame with random payload; a release may slip in between payload bytes
  function automatic void push_frame(logic [7:0] hdr, logic [15:0] len, logic [7:0] id,
                                     logic [7:0] cmd, logic [7:0] ftr, int rel_pct);
    int i;
    push_byte(hdr);
    push_byte(len[15:8]);
    push_byte(len[7:0]);
    push_byte(id);
    push_byte(cmd);
    for (i = 0; i < int'(len) - 6; i++) begin
      if ($urandom_range(0, 99) < rel_pct) push_release();
      push_byte(8'($urandom_range(0, 255)));
    end
    push_byte(ftr);
  endfunction

  // Mostly well-formed frames, plus releases, broken headers and lengths, noise
  function automatic void gen_traffic(logic [7:0] hdr, logic [7:0] ftr, int n, int rel_pct);
    int          stop;
    int          sel;
    int          pick;
    logic [15:0] len;
    logic [7:0]  id;
    logic [7:0]  f;
    stop = items_queued + n;
    while (items_queued < stop) begin
      sel = $urandom_range(0, 99);
      if (sel < rel_pct) begin
        repeat ($urandom_range(1, 2)) push_release();
      end else if (sel < rel_pct + 12) begin
        push_byte(hdr ^ 8'($urandom_range(1, 255)));
        push_byte(8'($urandom_range(0, 255)));
        push_byte(8'($urandom_range(0, 255)));
      end else if (sel < rel_pct + 20) begin
        len = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 5))
                                          : 16'($urandom_range(262, 65535));
        push_byte(hdr);
        push_byte(len[15:8]);
        push_byte(len[7:0]);
      end else if (sel < rel_pct + 24) begin
        repeat (3) push_byte(8'($urandom_range(0, 255)));
      end else begin
        pick = $urandom_range(0, 29);
        if (pick == 0) len = MAX_FRAME_LEN;
        else if (pick == 1) len = 16'($urandom_range(6, 261));
        else len = 16'($urandom_range(6, 14));
        id = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 11))
                                         : 8'($urandom_range(0, 255));
        f = ($urandom_range(0, 11) == 0) ? ftr ^ 8'($urandom_range(1, 255)) : ftr;
        push_frame(hdr, len, id, 8'($urandom_range(0, 255)), f, 3);
      end
    end
  endfunction

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [7:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= {24'b0, data};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_config(input logic [7:0] hdr, input logic [7:0] ftr);
    apb_access(1'b1, ADDR_HEADER, hdr);
    apb_access(1'b1, ADDR_FOOTER, ftr);
    apb_access(1'b0, ADDR_HEADER, 8'h00);
    apb_access(1'b0, ADDR_FOOTER, 8'h00);
  endtask

  // Hold until every transaction is sent and every report is back
  task automatic drain();
    while (rx_items.size() != 0 || in_valid || frame_reports_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input logic [7:0] hdr, input logic [7:0] ftr, input int rel_pct);
    write_config(hdr, ftr);
    gen_traffic(hdr, ftr, 255, rel_pct);
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_config(8'h00, 8'hFF);
    // release on an empty table: nothing comes back
    push_release();
    // minimal frame, no payload
    push_byte(8'h00); push_byte(8'h00); push_byte(8'h06);
    push_byte(8'hFF); push_byte(8'h00); push_byte(8'hFF);
    // wrong header and too short a length: header wins
    push_byte(8'h7E); push_byte(8'h00); push_byte(8'h00);
    // length one past the maximum, then one below the minimum
    push_byte(8'h00); push_byte(8'h01); push_byte(8'h06);
    push_byte(8'h00); push_byte(8'h00); push_byte(8'h05);
    // one payload byte with a release landing mid-frame
    push_byte(8'h00); push_byte(8'h00); push_byte(8'h07);
    push_byte(8'h00); push_byte(8'hFF); push_release();
    push_byte(8'h80); push_byte(8'hFF);
    push_release();
    drain();

    run_phase(8'hFF, 8'h00, 15);
    run_phase(8'hA5, 8'h5A, 35);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 25);
    run_phase(8'h00, 8'hFF, 45);
    run_phase(8'h7E, 8'h7E, 25);
    repeat (8) @(negedge clk);

    $display("Sent %0d transactions (%0d releases) over six register settings, %0d reports back",
             items_taken, releases_taken, reports_seen);
    $display("Reports: payload %0d queued %0d dropped %0d bad hdr %0d bad len %0d",
             kind_seen[KIND_PAYLOAD], kind_seen[KIND_QUEUED], kind_seen[KIND_DROPPED],
             kind_seen[KIND_BAD_HEADER], kind_seen[KIND_BAD_LENGTH]);
    $display("         bad ftr %0d duplicate %0d released %0d",
             kind_seen[KIND_BAD_FOOTER], kind_seen[KIND_DUPLICATE], kind_seen[KIND_RELEASED]);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/cfd_pkg.sv
rtl/cfd_cfg.sv
rtl/cfd_pending.sv
rtl/cfd_parser.sv
rtl/command_frame_deframer_top.sv
tb/tb.sv
